// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the back end RTL of the zone alarm block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("Same-cycle assertion failed.");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("Next-cycle assertion failed.");
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/core/lrz_pkg.sv =====
// Package with the types, constants and sine table function of the zone alarm block.
package lrz_pkg;

  localparam int unsigned CfgIndexW = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned QueueDepth = 4;
  localparam logic [15:0] QuarterTurn = 16'd16384;
  localparam longint unsigned HalfPiQ30 = 64'd1686629713;
  localparam longint unsigned OneQ15 = 64'd32768;

  typedef enum logic [CfgIndexW-1:0] {
    REG_HALF_WIDTH  = 3'd0,
    REG_LENGTH      = 3'd1,
    REG_RIGHT_EDGE  = 3'd2,
    REG_LEFT_EDGE   = 3'd3,
    REG_ANGLE_STEP  = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [9:0]  right_edge_index;
    logic [9:0]  left_edge_index;
    logic [15:0] angle_step;
  } cfg_front_t;

  typedef struct packed {
    logic [15:0] half_width_mm;
    logic [15:0] length_mm;
  } cfg_back_t;

  typedef struct packed {
    logic [15:0] range_mm;
    logic [15:0] phase;
    logic        checked;
    logic        last_beam;
  } item_t;

  typedef struct packed {
    logic alarm;
    logic estop_request;
    logic clear_request;
  } result_t;

  // Sine in unsigned Q1.15 of an angle x given in Q2.30 radians.
  function automatic logic [15:0] sine_from_x(input longint unsigned x);
    longint unsigned x2;
    longint unsigned term;
    longint unsigned sum;
    longint unsigned v;
    x2 = (x * x) >> 30;
    term = x;
    sum = x;
    term = ((term * x2) >> 30) / 64'd6;
    sum = (sum >= term) ? sum - term : 64'd0;
    term = ((term * x2) >> 30) / 64'd20;
    sum = sum + term;
    term = ((term * x2) >> 30) / 64'd42;
    sum = (sum >= term) ? sum - term : 64'd0;
    term = ((term * x2) >> 30) / 64'd72;
    sum = sum + term;
    term = ((term * x2) >> 30) / 64'd110;
    sum = (sum >= term) ? sum - term : 64'd0;
    term = ((term * x2) >> 30) / 64'd156;
    sum = sum + term;
    v = (sum + 64'd16384) >> 15;
    if (v > OneQ15) begin
      v = OneQ15;
    end
    return v[15:0];
  endfunction

endpackage

// ===== rtl/core/lrz_if.sv =====
// Handshake interfaces for the ping requests and the alarm results.
interface lrz_ping_if;
  logic        valid;
  logic        ready;
  logic [15:0] range_mm;
  logic [9:0]  beam_index;
  logic        last_beam;

  modport source(output valid, output range_mm, output beam_index, output last_beam,
                 input ready);
  modport sink(input valid, input range_mm, input beam_index, input last_beam,
               output ready);
endinterface

interface lrz_alarm_if;
  logic valid;
  logic ready;
  logic alarm;
  logic estop_request;
  logic clear_request;

  modport source(output valid, output alarm, output estop_request, output clear_request,
                 input ready);
  modport sink(input valid, input alarm, input estop_request, input clear_request,
               output ready);
endinterface

// ===== rtl/core/lidar_rectangle_zone_alarm_unit.sv =====
// A final ping's alarm result passes through the queue, stage registers s1, s2, s3 and the result register.
// Throughput: one ping per cycle; a stall on the result side backs up the queue.
// The back end has four stages: phase to index, sine lookup, products and test.
// Reset restores the default rectangle and window, empties the queue and clears both flags.
// Top level of the lidar rectangle zone alarm unit.
module lidar_rectangle_zone_alarm_unit #(
  parameter int MAX_BEAMS        = 1024,
  parameter int SINE_TABLE_DEPTH = 256,
  parameter int RANGE_BITS       = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [lrz_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [lrz_pkg::CfgDataW-1:0]  cfg_wdata_i,
  lrz_ping_if.sink                     ping_i,
  lrz_alarm_if.source                  result_o
);

  lrz_pkg::cfg_front_t cfg_front_q;
  lrz_pkg::cfg_back_t  cfg_back_q;
  lrz_pkg::item_t      push_item;
  lrz_pkg::item_t      head_item;
  logic                push;
  logic                pop;
  logic                full;
  logic                empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_back_q.half_width_mm <= 16'd500;
      cfg_back_q.length_mm <= 16'd2000;
      cfg_front_q.right_edge_index <= 10'd0;
      cfg_front_q.left_edge_index <= 10'd1023;
      cfg_front_q.angle_step <= 16'd64;
    end else if (cfg_we_i) begin
      case (lrz_pkg::reg_idx_e'(cfg_index_i))
        lrz_pkg::REG_HALF_WIDTH: cfg_back_q.half_width_mm <= cfg_wdata_i;
        lrz_pkg::REG_LENGTH:     cfg_back_q.length_mm <= cfg_wdata_i;
        lrz_pkg::REG_RIGHT_EDGE: cfg_front_q.right_edge_index <= cfg_wdata_i[9:0];
        lrz_pkg::REG_LEFT_EDGE:  cfg_front_q.left_edge_index <= cfg_wdata_i[9:0];
        lrz_pkg::REG_ANGLE_STEP: cfg_front_q.angle_step <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  lrz_front #(
    .MAX_BEAMS (MAX_BEAMS),
    .RANGE_BITS(RANGE_BITS)
  ) u_front (
    .ping_i(ping_i),
    .cfg_i (cfg_front_q),
    .full_i(full),
    .push_o(push),
    .item_o(push_item)
  );

  lrz_queue #(
    .DEPTH(lrz_pkg::QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (push_item),
    .pop_i  (pop),
    .item_o (head_item),
    .full_o (full),
    .empty_o(empty)
  );

  lrz_back #(
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (head_item),
    .item_valid_i(!empty),
    .item_pop_o  (pop),
    .cfg_i       (cfg_back_q),
    .result_o    (result_o)
  );

endmodule

// ===== rtl/core/lrz_front.sv =====
// Front end: accepts pings, checks the beam window and computes the beam phase.
module lrz_front #(
  parameter int MAX_BEAMS  = 1024,
  parameter int RANGE_BITS = 16
) (
  lrz_ping_if.sink           ping_i,
  input  lrz_pkg::cfg_front_t cfg_i,
  input  logic               full_i,
  output logic               push_o,
  output lrz_pkg::item_t     item_o
);

  localparam logic [15:0] RangeMask =
      (RANGE_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << RANGE_BITS) - 32'd1);

  logic [15:0] beam_offset;
  logic [31:0] phase_full;
  logic        in_window;

  assign ping_i.ready = !full_i;
  assign push_o = ping_i.valid && !full_i;

  always_comb begin
    beam_offset = 16'(ping_i.beam_index) - 16'(cfg_i.right_edge_index);
    phase_full = 32'(beam_offset) * 32'(cfg_i.angle_step);
    in_window = (int'(ping_i.beam_index) < MAX_BEAMS) &&
                (ping_i.beam_index >= cfg_i.right_edge_index) &&
                (ping_i.beam_index <= cfg_i.left_edge_index);
    item_o.range_mm = ping_i.range_mm & RangeMask;
    item_o.phase = phase_full[15:0];
    item_o.checked = in_window;
    item_o.last_beam = ping_i.last_beam;
  end

endmodule

// ===== rtl/core/lrz_queue.sv =====
// Short queue that decouples the front end from the back end.
module lrz_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  lrz_pkg::item_t item_i,
  input  logic           pop_i,
  output lrz_pkg::item_t item_o,
  output logic           full_o,
  output logic           empty_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  lrz_pkg::item_t entry_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push;
  logic            do_pop;

  assign full_o = (count_q == FullCnt);
  assign empty_o = (count_q == '0);
  assign item_o = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// ===== rtl/core/lrz_back.sv =====
// Back end: sine lookup, rectangle test, sticky scan flag and alarm result register.
`include "assert_macros.svh"

module lrz_back #(
  parameter int SINE_TABLE_DEPTH = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lrz_pkg::item_t    item_i,
  input  logic              item_valid_i,
  output logic              item_pop_o,
  input  lrz_pkg::cfg_back_t cfg_i,
  lrz_alarm_if.source       result_o
);

  localparam int IdxW = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int ProdW = 14 + IdxW;
  localparam logic [IdxW-1:0] DepthIdx = IdxW'(SINE_TABLE_DEPTH);

  logic [15:0] sine_rom [SINE_TABLE_DEPTH + 1];

  for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_rom
    localparam longint unsigned AngleQ30 =
        (lrz_pkg::HalfPiQ30 * 64'(k)) / SINE_TABLE_DEPTH;
    assign sine_rom[k] = lrz_pkg::sine_from_x(AngleQ30);
  end

  logic            advance;
  logic            take;
  logic [15:0]     cos_phase;
  logic [ProdW-1:0] sin_prod;
  logic [ProdW-1:0] cos_prod;
  logic [IdxW-1:0] sin_raw;
  logic [IdxW-1:0] cos_raw;
  logic [IdxW-1:0] sin_idx_d;
  logic [IdxW-1:0] cos_idx_d;

  logic            s1_valid_q, s2_valid_q, s3_valid_q;
  logic            s1_checked_q, s2_checked_q, s3_checked_q;
  logic            s1_last_q, s2_last_q, s3_last_q;
  logic            s1_neg_q, s2_neg_q, s3_neg_q;
  logic [15:0]     s1_range_q, s2_range_q;
  logic [IdxW-1:0] s1_sin_idx_q, s1_cos_idx_q;
  logic [15:0]     s2_sin_mag_q, s2_cos_mag_q;
  logic [31:0]     s3_len_prod_q, s3_wid_prod_q;

  logic            len_ok;
  logic            wid_ok;
  logic            scan_alarm;
  logic            scan_blocked_q, scan_blocked_d;
  logic            prev_alarm_q, prev_alarm_d;
  logic            res_valid_q, res_valid_d;
  lrz_pkg::result_t res_q, res_d;

  assign advance = !res_valid_q || result_o.ready;
  assign take = advance && item_valid_i;
  assign item_pop_o = take;

  always_comb begin
    cos_phase = item_i.phase + lrz_pkg::QuarterTurn;
    sin_prod = ProdW'(item_i.phase[13:0]) * ProdW'(SINE_TABLE_DEPTH);
    cos_prod = ProdW'(cos_phase[13:0]) * ProdW'(SINE_TABLE_DEPTH);
    sin_raw = sin_prod[ProdW-1:14];
    cos_raw = cos_prod[ProdW-1:14];
    sin_idx_d = item_i.phase[14] ? DepthIdx - sin_raw : sin_raw;
    cos_idx_d = cos_phase[14] ? DepthIdx - cos_raw : cos_raw;
  end

  always_comb begin
    len_ok = s3_neg_q || (s3_len_prod_q <= {1'b0, cfg_i.length_mm, 15'd0});
    wid_ok = s3_wid_prod_q <= {1'b0, cfg_i.half_width_mm, 15'd0};
    scan_alarm = scan_blocked_q || (s3_checked_q && len_ok && wid_ok);
    scan_blocked_d = scan_blocked_q;
    prev_alarm_d = prev_alarm_q;
    res_valid_d = res_valid_q;
    res_d = res_q;
    if (advance) begin
      res_valid_d = s3_valid_q && s3_last_q;
      if (s3_valid_q) begin
        if (s3_last_q) begin
          res_d.alarm = scan_alarm;
          res_d.estop_request = scan_alarm && !prev_alarm_q;
          res_d.clear_request = !scan_alarm && prev_alarm_q;
          prev_alarm_d = scan_alarm;
          scan_blocked_d = 1'b0;
        end else begin
          scan_blocked_d = scan_alarm;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      scan_blocked_q <= 1'b0;
      prev_alarm_q <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        s1_valid_q <= take;
        s2_valid_q <= s1_valid_q;
        s3_valid_q <= s2_valid_q;
      end
      scan_blocked_q <= scan_blocked_d;
      prev_alarm_q <= prev_alarm_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (advance) begin
      s1_range_q <= item_i.range_mm;
      s1_checked_q <= item_i.checked;
      s1_last_q <= item_i.last_beam;
      s1_neg_q <= item_i.phase[15];
      s1_sin_idx_q <= sin_idx_d;
      s1_cos_idx_q <= cos_idx_d;

      s2_range_q <= s1_range_q;
      s2_checked_q <= s1_checked_q;
      s2_last_q <= s1_last_q;
      s2_neg_q <= s1_neg_q;
      s2_sin_mag_q <= sine_rom[s1_sin_idx_q];
      s2_cos_mag_q <= sine_rom[s1_cos_idx_q];

      s3_checked_q <= s2_checked_q;
      s3_last_q <= s2_last_q;
      s3_neg_q <= s2_neg_q;
      s3_len_prod_q <= 32'(s2_range_q) * 32'(s2_sin_mag_q);
      s3_wid_prod_q <= 32'(s2_range_q) * 32'(s2_cos_mag_q);
    end
  end

  assign result_o.valid = res_valid_q;
  assign result_o.alarm = res_q.alarm;
  assign result_o.estop_request = res_q.estop_request;
  assign result_o.clear_request = res_q.clear_request;

  `ASSERT_IMPL(a_edge_exclusive, clk_i, rst_ni, res_valid_q, !(res_q.estop_request && res_q.clear_request))
  `ASSERT_IMPL(a_prev_tracks_result, clk_i, rst_ni, res_valid_q, prev_alarm_q == res_q.alarm)
  `ASSERT_NEXT(a_flag_cleared, clk_i, rst_ni, advance && s3_valid_q && s3_last_q, !scan_blocked_q)

endmodule
